### rtl/flb_pkg.sv
// Package for the fixed low-pass FIR: the Q1.17 tap table and its lookup.
// Used by flb_cell and fir_lowpass_blackman; depends on nothing.
package flb_pkg;

  localparam int COEF_W     = 18;
  localparam int COEF_FRAC  = 17;
  localparam int COEF_COUNT = 20;

  typedef logic signed [COEF_W-1:0] coef_t;

  // Blackman-windowed sinc, Fc = 0.0175, normalized to unit sum, signed Q1.17
  localparam coef_t COEFS [COEF_COUNT] = '{
    18'sd0,     18'sd206,   18'sd901,   18'sd2263,  18'sd4426,
    18'sd7323,  18'sd10608, 18'sd13701, 18'sd15946, 18'sd16828,
    18'sd16146, 18'sd14080, 18'sd11124, 18'sd7908,  18'sd5003,
    18'sd2763,  18'sd1287,  18'sd464,   18'sd96,    18'sd0
  };

  // taps past the table count as zero
  function automatic coef_t coef_at(input int k);
    coef_t c;
    c = '0;
    if (k >= 0 && k < COEF_COUNT) begin
      c = COEFS[k];
    end
    return c;
  endfunction

endpackage

### rtl/flb_cell.sv
// One tap of the transposed-form FIR: multiply the sample, add the neighbor's
// partial sum and hold the result. Depends on flb_pkg.
module flb_cell #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int ACC_W        = 39,
  parameter flb_pkg::coef_t COEF = '0
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           clear,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic signed [ACC_W-1:0]        sum_in,
  output logic signed [ACC_W-1:0]        sum_out
);
  import flb_pkg::*;

  localparam int PROD_W = SAMPLE_WIDTH + COEF_W;

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  sum_r;
  logic signed [ACC_W-1:0]  sum_nxt;

  assign prod     = PROD_W'(sample) * PROD_W'(COEF);
  assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

  // block start: contributions of older samples are dropped
  assign sum_nxt = clear ? prod_ext : prod_ext + sum_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (en) begin
      sum_r <= sum_nxt;
    end
  end

  assign sum_out = sum_r;

endmodule

### rtl/fir_lowpass_blackman.sv
// Fixed low-pass FIR (Blackman-windowed sinc, Q1.17 taps), top level.
// Depends on flb_pkg and flb_cell.
//
// Takes one sample per clock and returns one filtered sample per request,
// in the cycle after acceptance. The filter is a transposed chain of TAPS-1
// cells, each a multiply-add and a register; the cell next to the output
// holds the full sum, which is rounded to nearest (ties up) and saturated
// on the way out. A request with block_start set drops all earlier history.
// Input is stalled only while a result waits and the output is stalled.
module fir_lowpass_blackman #(
  parameter int TAPS         = 20,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  input  logic                           in_block_start,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample_out
);
  import flb_pkg::*;

  localparam int ACC_W = SAMPLE_WIDTH + COEF_W + $clog2(TAPS);
  localparam int Q_W   = ACC_W + 1 - COEF_FRAC;
  localparam logic signed [ACC_W:0] ROUND_HALF = (ACC_W+1)'(1) << (COEF_FRAC - 1);
  localparam logic signed [Q_W-1:0] MAXV = Q_W'((64'(1) << (SAMPLE_WIDTH - 1)) - 64'(1));
  localparam logic signed [Q_W-1:0] MINV = -MAXV - Q_W'(1);

  logic                    accept;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic signed [ACC_W-1:0] part [TAPS];
  logic signed [ACC_W:0]   rnd;
  logic signed [Q_W-1:0]   q;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign part[TAPS-1] = '0;

  for (genvar k = 0; k < TAPS - 1; k++) begin : g_cell
    flb_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .ACC_W       (ACC_W),
      .COEF        (coef_at(k))
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (accept),
      .clear  (in_block_start),
      .sample (in_sample_in),
      .sum_in (part[k+1]),
      .sum_out(part[k])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // floor((acc + half) / 2^17), then clamp
  assign rnd = {part[0][ACC_W-1], part[0]} + ROUND_HALF;
  assign q   = rnd[ACC_W:COEF_FRAC];

  always_comb begin
    if (q > MAXV) begin
      out_sample_out = MAXV[SAMPLE_WIDTH-1:0];
    end else if (q < MINV) begin
      out_sample_out = MINV[SAMPLE_WIDTH-1:0];
    end else begin
      out_sample_out = q[SAMPLE_WIDTH-1:0];
    end
  end

  assign out_valid = out_valid_r;

endmodule
